// ===== sv/i2p_pkg.sv =====
// Shared types, codes and lookup functions for the infix-to-postfix converter.
`timescale 1ns / 1ps

package i2p_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [2:0]        op_code_t;
  typedef logic [1:0]        status_t;
  typedef logic [2:0]        prio_t;

  localparam op_code_t OP_NONE  = 3'd0;
  localparam op_code_t OP_OPEN  = 3'd1;
  localparam op_code_t OP_PLUS  = 3'd2;
  localparam op_code_t OP_MINUS = 3'd3;
  localparam op_code_t OP_MUL   = 3'd4;
  localparam op_code_t OP_DIV   = 3'd5;
  localparam op_code_t OP_POW   = 3'd6;

  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_OVERFLOW  = 2'd1;
  localparam status_t ST_UNMATCHED = 2'd2;

  localparam logic [7:0] CHAR_OPEN  = 8'h28;
  localparam logic [7:0] CHAR_CLOSE = 8'h29;
  localparam logic [7:0] CHAR_MUL   = 8'h2A;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_DIV   = 8'h2F;
  localparam logic [7:0] CHAR_POW   = 8'h5E;
  localparam logic [7:0] CHAR_NUL   = 8'h00;

  // Write/read request to the operator stack memory
  typedef struct packed {
    logic     we;
    addr_t    waddr;
    op_code_t wdata;
    addr_t    raddr;
  } stack_req_t;

  function automatic op_code_t char_to_op(input logic [7:0] c);
    op_code_t r;
    case (c)
      CHAR_OPEN:  r = OP_OPEN;
      CHAR_PLUS:  r = OP_PLUS;
      CHAR_MINUS: r = OP_MINUS;
      CHAR_MUL:   r = OP_MUL;
      CHAR_DIV:   r = OP_DIV;
      CHAR_POW:   r = OP_POW;
      default:    r = OP_NONE;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] op_to_char(input op_code_t c);
    logic [7:0] r;
    case (c)
      OP_OPEN:  r = CHAR_OPEN;
      OP_PLUS:  r = CHAR_PLUS;
      OP_MINUS: r = CHAR_MINUS;
      OP_MUL:   r = CHAR_MUL;
      OP_DIV:   r = CHAR_DIV;
      OP_POW:   r = CHAR_POW;
      default:  r = CHAR_NUL;
    endcase
    return r;
  endfunction

  function automatic prio_t op_prio(input op_code_t c);
    prio_t r;
    case (c)
      OP_OPEN:          r = 3'd1;
      OP_PLUS, OP_MINUS: r = 3'd2;
      OP_MUL, OP_DIV:   r = 3'd3;
      OP_POW:           r = 3'd4;
      default:          r = 3'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== sv/i2p_stack.sv =====
// Operator stack memory with a registered top-of-stack read and write forwarding.
`timescale 1ns / 1ps

module i2p_stack (
  input  logic                clk,
  input  i2p_pkg::stack_req_t req,
  output i2p_pkg::op_code_t   top
);
  import i2p_pkg::*;

  op_code_t mem [STACK_DEPTH];
  op_code_t top_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // a push lands on the entry being read in the same cycle: bypass the array
  always_ff @(posedge clk) begin
    if (req.we && (req.waddr == req.raddr)) begin
      top_r <= req.wdata;
    end else begin
      top_r <= mem[req.raddr];
    end
  end

  assign top = top_r;

endmodule

// ===== sv/infix_to_postfix_converter.sv =====
// Top level of the shunting-yard infix-to-postfix converter.
//
// Input channel: in_char with in_end_of_line, taken when in_valid is high and
// in_stall low. One request is worked on at a time; in_stall stays high until
// every result of the current request has been handed to the output register.
// Result channel: out_char, out_status and out_last_of_run, offered while
// out_valid is high and taken when out_stall is low. out_last_of_run marks the
// final result of each input request; a request may give no result at all.
// Sequence: a request passes from idle through the work and flush states and
// back to idle; each operator popped from the stack adds a step, and a step
// waits while the output is full. The top entry of the stack memory is held in
// a register fed by the read port with forwarding from the write port.
// The last result of a request is offered from the cycle in which in_stall drops.
// While out_stall is high the sequencer holds at the next result and the
// input side stays stalled; nothing is lost or repeated.
// Reset (rst_n low, synchronous) empties the stack and drops any result
// not yet taken; the stack memory itself is not cleared.
`timescale 1ns / 1ps

module infix_to_postfix_converter (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char,
  input  logic       in_end_of_line,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_char,
  output i2p_pkg::status_t out_status,
  output logic       out_last_of_run
);
  import i2p_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WORK,
    S_FLUSH
  } state_t;

  state_t     state_r, state_nxt;
  cnt_t       cnt_r, cnt_nxt;
  logic [7:0] char_r;
  logic       eol_r;

  logic       pend_v_r, pend_v_nxt;
  logic [7:0] pend_char_r, pend_char_nxt;
  status_t    pend_st_r, pend_st_nxt;

  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_char_r, out_char_nxt;
  status_t    out_st_r, out_st_nxt;
  logic       out_last_r, out_last_nxt;

  stack_req_t req;
  op_code_t   top;
  op_code_t   code;
  logic       has_top;
  logic       can_out;
  logic       adv;
  logic       gen;
  logic       fin;
  logic [7:0] gen_char;
  status_t    gen_st;

  i2p_stack u_stack (
    .clk (clk),
    .req (req),
    .top (top)
  );

  assign in_stall        = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_char        = out_char_r;
  assign out_status      = out_st_r;
  assign out_last_of_run = out_last_r;

  assign code    = char_to_op(char_r);
  assign has_top = (cnt_r != '0);
  assign can_out = !out_valid_r || !out_stall;
  // a step may release the held result, so it waits for room at the output
  assign adv     = !pend_v_r || can_out;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    gen           = 1'b0;
    fin           = 1'b0;
    gen_char      = CHAR_NUL;
    gen_st        = ST_OK;
    req.we        = 1'b0;
    req.waddr     = cnt_r[ADDR_W-1:0];
    req.wdata     = code;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_WORK;
        end
      end
      S_WORK: begin
        if (adv) begin
          if (char_r == CHAR_CLOSE) begin
            if (has_top && (top != OP_OPEN)) begin
              gen      = 1'b1;
              gen_char = op_to_char(top);
              cnt_nxt  = cnt_r - 1'b1;
            end else if (has_top) begin
              cnt_nxt   = cnt_r - 1'b1;
              state_nxt = S_FLUSH;
            end else begin
              gen       = 1'b1;
              gen_st    = ST_UNMATCHED;
              state_nxt = S_FLUSH;
            end
          end else if (code != OP_NONE) begin
            if ((code != OP_OPEN) && has_top && (op_prio(code) <= op_prio(top))) begin
              gen      = 1'b1;
              gen_char = op_to_char(top);
              cnt_nxt  = cnt_r - 1'b1;
            end else begin
              if (cnt_r >= CNT_W'(STACK_DEPTH)) begin
                gen    = 1'b1;
                gen_st = ST_OVERFLOW;
              end else begin
                req.we  = 1'b1;
                cnt_nxt = cnt_r + 1'b1;
              end
              state_nxt = S_FLUSH;
            end
          end else begin
            gen       = 1'b1;
            gen_char  = char_r;
            state_nxt = S_FLUSH;
          end
        end
      end
      S_FLUSH: begin
        if (adv) begin
          if (eol_r && has_top) begin
            gen      = 1'b1;
            gen_char = op_to_char(top);
            cnt_nxt  = cnt_r - 1'b1;
          end else begin
            fin       = 1'b1;
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // keep the top register tracking the entry below the new count
    req.raddr = ADDR_W'(cnt_nxt - 1'b1);
  end

  // One result is held back until it is known whether another follows.
  always_comb begin
    pend_v_nxt    = pend_v_r;
    pend_char_nxt = pend_char_r;
    pend_st_nxt   = pend_st_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_char_nxt  = out_char_r;
    out_st_nxt    = out_st_r;
    out_last_nxt  = out_last_r;

    if (gen || fin) begin
      if (pend_v_r) begin
        out_valid_nxt = 1'b1;
        out_char_nxt  = pend_char_r;
        out_st_nxt    = pend_st_r;
        out_last_nxt  = fin;
      end
      pend_v_nxt    = gen;
      pend_char_nxt = gen_char;
      pend_st_nxt   = gen_st;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
    pend_char_r <= pend_char_nxt;
    pend_st_r   <= pend_st_nxt;
    out_char_r  <= out_char_nxt;
    out_st_r    <= out_st_nxt;
    out_last_r  <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      char_r <= in_char;
      eol_r  <= in_end_of_line;
    end
  end

endmodule
